// ----- design/ltlv_pkg.sv -----
// Package for the LwM2M TLV stream parser.
// Holds result codes, item and result structs, and the result queue constants.
`timescale 1ns / 1ps

package ltlv_pkg;

    // result kinds
    localparam logic [1:0] KIND_HEADER = 2'd0;
    localparam logic [1:0] KIND_VALUE  = 2'd1;
    localparam logic [1:0] KIND_CUT    = 2'd2;

    // result queue: room for the two results one input item can cause, plus slack
    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       source_end;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  id_kind;
        logic [15:0] identifier;
        logic [23:0] value_length;
        logic [7:0]  value_byte;
        logic        entry_end;
    } t_result;

    // up to two results per accepted item; v1 is set only together with v0
    typedef struct packed {
        logic    v0;
        logic    v1;
        t_result r0;
        t_result r1;
    } t_res_pair;

endpackage

// ----- design/ltlv_in_if.sv -----
// Input channel of the TLV parser: one source octet per item.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps

interface ltlv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       source_end;

    modport source (output valid, output data_byte, output source_end, input ready);
    modport sink   (input valid, input data_byte, input source_end, output ready);
endinterface

// ----- design/ltlv_out_if.sv -----
// Output channel of the TLV parser: one header, value or cut-short result per item.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps

interface ltlv_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [1:0]  id_kind;
    logic [15:0] identifier;
    logic [23:0] value_length;
    logic [7:0]  value_byte;
    logic        entry_end;

    modport source (output valid, output kind, output id_kind, output identifier,
                    output value_length, output value_byte, output entry_end,
                    input ready);
    modport sink   (input valid, input kind, input id_kind, input identifier,
                    input value_length, input value_byte, input entry_end,
                    output ready);
endinterface

// ----- design/ltlv_parser.sv -----
// TLV decode state machine: per accepted octet, updates the parse state and
// produces up to two results. Depends on ltlv_pkg.
`timescale 1ns / 1ps

module ltlv_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  ltlv_pkg::t_in_item  i_item,
    output ltlv_pkg::t_res_pair o_res
);

    typedef enum logic [2:0] {
        PH_TYPE  = 3'd0,
        PH_ID_HI = 3'd1,
        PH_ID_LO = 3'd2,
        PH_LEN   = 3'd3,
        PH_VALUE = 3'd4
    } t_phase;

    t_phase      r_phase,  n_phase;
    logic [7:0]  r_hdr,    n_hdr;
    logic [15:0] r_ident,  n_ident;
    logic [1:0]  r_lol,    n_lol;
    logic [23:0] r_bytes,  n_bytes;

    ltlv_pkg::t_result w_main;
    ltlv_pkg::t_result w_cut;
    logic              w_main_v;
    logic [7:0]        w_b;
    logic [1:0]        w_lentype;
    logic [1:0]        w_lol_dec;
    logic [23:0]       w_len;
    logic [23:0]       w_left;

    assign w_b       = i_item.data_byte;
    assign w_lentype = r_hdr[4:3];
    assign w_len     = {r_bytes[15:0], w_b};
    assign w_lol_dec = (r_lol != 2'd0) ? r_lol - 2'd1 : 2'd0;
    assign w_left    = (r_bytes != 24'd0) ? r_bytes - 24'd1 : 24'd0;

    always_comb begin
        n_phase  = r_phase;
        n_hdr    = r_hdr;
        n_ident  = r_ident;
        n_lol    = r_lol;
        n_bytes  = r_bytes;
        w_main_v = 1'b0;
        w_main   = '0;

        case (r_phase)
            PH_ID_HI: begin
                n_ident = {w_b, 8'h00};
                n_phase = PH_ID_LO;
            end
            PH_ID_LO: begin
                n_ident = {r_ident[15:8], w_b};
                if (w_lentype == 2'd0) begin
                    n_bytes              = {21'd0, r_hdr[2:0]};
                    w_main_v             = 1'b1;
                    w_main.kind          = ltlv_pkg::KIND_HEADER;
                    w_main.value_length  = {21'd0, r_hdr[2:0]};
                    w_main.entry_end     = (r_hdr[2:0] == 3'd0);
                    n_phase              = (r_hdr[2:0] != 3'd0) ? PH_VALUE : PH_TYPE;
                end else begin
                    n_lol   = w_lentype;
                    n_bytes = 24'd0;
                    n_phase = PH_LEN;
                end
            end
            PH_LEN: begin
                n_bytes = w_len;
                n_lol   = w_lol_dec;
                if (w_lol_dec == 2'd0) begin
                    w_main_v            = 1'b1;
                    w_main.kind         = ltlv_pkg::KIND_HEADER;
                    w_main.value_length = w_len;
                    w_main.entry_end    = (w_len == 24'd0);
                    n_phase             = (w_len != 24'd0) ? PH_VALUE : PH_TYPE;
                end
            end
            PH_VALUE: begin
                n_bytes           = w_left;
                w_main_v          = 1'b1;
                w_main.kind       = ltlv_pkg::KIND_VALUE;
                w_main.value_byte = w_b;
                w_main.entry_end  = (w_left == 24'd0);
                if (w_left == 24'd0) begin
                    n_phase = PH_TYPE;
                end
            end
            default: begin
                // type byte; unused phase codes land here too
                n_hdr   = w_b;
                n_ident = 16'd0;
                n_lol   = 2'd0;
                n_bytes = 24'd0;
                n_phase = w_b[5] ? PH_ID_HI : PH_ID_LO;
            end
        endcase

        // results carry the entry fields as they stand after this octet
        w_main.id_kind    = n_hdr[7:6];
        w_main.identifier = n_ident;

        w_cut              = '0;
        w_cut.kind         = ltlv_pkg::KIND_CUT;
        w_cut.id_kind      = n_hdr[7:6];
        w_cut.identifier   = n_ident;
        w_cut.entry_end    = 1'b1;

        o_res.v0 = w_main_v;
        o_res.v1 = 1'b0;
        o_res.r0 = w_main;
        o_res.r1 = w_cut;

        // source ran out inside an entry
        if (i_item.source_end && (n_phase != PH_TYPE)) begin
            if (w_main_v) begin
                o_res.v1 = 1'b1;
            end else begin
                o_res.v0 = 1'b1;
                o_res.r0 = w_cut;
            end
            n_phase = PH_TYPE;
            n_lol   = 2'd0;
            n_bytes = 24'd0;
        end

        if (!i_accept) begin
            o_res.v0 = 1'b0;
            o_res.v1 = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TYPE;
            r_hdr   <= 8'd0;
            r_ident <= 16'd0;
            r_lol   <= 2'd0;
            r_bytes <= 24'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_hdr   <= n_hdr;
            r_ident <= n_ident;
            r_lol   <= n_lol;
            r_bytes <= n_bytes;
        end
    end

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.v1 |-> o_res.v0)
        else $error("second result without a first");

    a_second_is_cut: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.v1 |-> (o_res.r1.kind == ltlv_pkg::KIND_CUT) && o_res.r1.entry_end)
        else $error("second result is not a cut-short result");

    a_cut_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_item.source_end) |=> (r_phase == PH_TYPE) && (r_bytes == 24'd0))
        else $error("parser not back at type byte after source end");

endmodule

// ----- design/ltlv_res_queue.sv -----
// Result queue: takes up to two results per cycle, hands out one per cycle.
// Depends on ltlv_pkg.
`timescale 1ns / 1ps

module ltlv_res_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ltlv_pkg::t_res_pair i_res,
    input  logic                i_pop,
    output logic                o_room,
    output logic                o_valid,
    output ltlv_pkg::t_result   o_head
);

    localparam int unsigned CW = ltlv_pkg::QAW + 1;

    ltlv_pkg::t_result r_mem [ltlv_pkg::QDEPTH];
    logic [ltlv_pkg::QAW-1:0] r_wr, r_rd;
    logic [ltlv_pkg::QAW-1:0] w_wr1;
    logic [CW-1:0]            r_count, n_count;
    logic [CW-1:0]            w_push_n;
    logic                     w_pop;

    assign w_push_n = CW'(i_res.v0) + CW'(i_res.v1);
    assign w_wr1    = r_wr + ltlv_pkg::QAW'(1);
    assign o_valid  = (r_count != '0);
    assign w_pop    = i_pop && o_valid;
    assign o_head   = r_mem[r_rd];
    // two free slots needed, since one item may cause two results
    assign o_room   = (r_count <= CW'(ltlv_pkg::QDEPTH - 2));
    assign n_count  = r_count + w_push_n - CW'(w_pop);

    always_ff @(posedge i_clk) begin
        if (i_res.v0) begin
            r_mem[r_wr] <= i_res.r0;
        end
        if (i_res.v1) begin
            r_mem[w_wr1] <= i_res.r1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + w_push_n[ltlv_pkg::QAW-1:0];
            r_rd    <= r_rd + ltlv_pkg::QAW'(w_pop);
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push_n != '0) |-> (r_count + w_push_n <= CW'(ltlv_pkg::QDEPTH)))
        else $error("result queue overflow");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(ltlv_pkg::QDEPTH))
        else $error("result count out of range");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr - r_rd) == r_count[ltlv_pkg::QAW-1:0])
        else $error("queue pointers disagree with count");

endmodule

// ----- design/lwm2m_tlv_stream_parser_top.sv -----
// Top level of the LwM2M TLV stream parser: input/output channels, parser, queue.
// Depends on ltlv_pkg, ltlv_in_if, ltlv_out_if, ltlv_parser, ltlv_res_queue.
//
// Usage:
//   i_in takes the TLV source one octet per item; source_end marks the last
//   octet of a source buffer. o_out gives one result per item: an entry header
//   (identifier kind, identifier, value length), then one value octet per item,
//   entry_end on the entry's last result. If a source ends inside an entry a
//   cut-short result follows; the consumer drops that entry.
//   A result is written to the queue as its octet is accepted and shows on o_out
//   once earlier results are taken. Throughput: one octet per cycle while
//   i_in.ready is high, as the parse state updates per octet. An octet that
//   ends a source mid-entry can cause two results, which leave o_out in turn.
//   Results pass through a four-entry queue; i_in.ready is high while two
//   slots are free, so input keeps flowing while results wait.
//   When o_out.ready is low, results collect in the queue and i_in.ready drops
//   once three or more wait; octets that cause no result still pass until then.
//   Nothing is lost.
//   Reset (i_rst_n low, synchronous) empties the queue and returns the parser
//   to expecting a type byte.
`timescale 1ns / 1ps

module lwm2m_tlv_stream_parser_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ltlv_in_if.sink           i_in,
    ltlv_out_if.source        o_out
);

    ltlv_pkg::t_in_item  w_item;
    ltlv_pkg::t_res_pair w_res;
    ltlv_pkg::t_result   w_head;
    logic                w_room;
    logic                w_accept;
    logic                w_valid;

    assign i_in.ready          = w_room;
    assign w_accept            = i_in.valid && w_room;
    assign w_item.data_byte    = i_in.data_byte;
    assign w_item.source_end   = i_in.source_end;

    ltlv_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_item   (w_item),
        .o_res    (w_res)
    );

    ltlv_res_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (w_res),
        .i_pop   (o_out.ready),
        .o_room  (w_room),
        .o_valid (w_valid),
        .o_head  (w_head)
    );

    assign o_out.valid        = w_valid;
    assign o_out.kind         = w_head.kind;
    assign o_out.id_kind      = w_head.id_kind;
    assign o_out.identifier   = w_head.identifier;
    assign o_out.value_length = w_head.value_length;
    assign o_out.value_byte   = w_head.value_byte;
    assign o_out.entry_end    = w_head.entry_end;

    a_accept_yields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in.source_end) |=> w_valid)
        else $error("no result pending after an item that ended the source");

endmodule
